### rtl/bfir_pkg.sv
// bfir_pkg: opcodes and fixed widths shared by the brainfuck ir executor
`default_nettype none

package bfir_pkg;

  localparam int OP_W      = 3;
  localparam int ARG_W     = 17;
  localparam int BYTE_W    = 8;
  localparam int IDX_OUT_W = 16;
  localparam int COUNT_W   = 16;

  // operand reduction: reciprocal multiply, then multiply and subtract
  localparam int RED_CYCLES = 2;
  localparam int MAG_W      = ARG_W;
  localparam int PROD_W     = 2 * ARG_W + 1;
  localparam int RED_CNT_W  = $clog2(RED_CYCLES + 1);

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 3'd0,
    OP_MOVE  = 3'd1,
    OP_ZERO  = 3'd2,
    OP_OUT   = 3'd3,
    OP_IN    = 3'd4,
    OP_JZ    = 3'd5,
    OP_JNZ   = 3'd6,
    OP_HALT  = 3'd7
  } op_t;

endpackage

`default_nettype wire

### rtl/brainfuck_ir_executor.sv
// brainfuck_ir_executor: folded brainfuck ir executor around a byte tape ram
`default_nettype none

// Executes one folded Brainfuck instruction per input item and returns one result
// item per instruction (next index to fetch, output byte and repeat count, halted).
// After reset the block sweeps the tape RAM to zero, one cell per cycle, so
// in_ready stays low until the sweep ends. The tape sits in a single-port-write,
// registered-read RAM: an item is accepted and its cell read is issued in the same
// cycle; the item then executes and writes back in the execute stage. Add, clear,
// out, in, jumps and halt sustain one item per cycle while the output register can
// take the result and no reduction runs; a write from the previous item is forwarded
// to the next. A move holds off the next item until it leaves execute, since the
// following read address comes from it. When TAPE_CELLS (for moves) or PROGRAM_OPS
// (for jumps) is not a power of two, the operand is reduced by a reciprocal multiply
// and a multiply-subtract on two registered steps before that item executes. A
// result waits in the output register while the next item executes.
module brainfuck_ir_executor #(
  parameter int TAPE_CELLS  = 32768,
  parameter int PROGRAM_OPS = 65536
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [bfir_pkg::OP_W-1:0]          op,
  input  wire logic signed [bfir_pkg::ARG_W-1:0]  operand,
  input  wire logic [bfir_pkg::BYTE_W-1:0]        in_byte,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [bfir_pkg::IDX_OUT_W-1:0]          next_index,
  output logic [bfir_pkg::BYTE_W-1:0]             out_byte,
  output logic [bfir_pkg::COUNT_W-1:0]            out_count,
  output logic                                    halted
);

  localparam int TW  = $clog2(TAPE_CELLS);
  localparam int PW  = $clog2(PROGRAM_OPS);
  localparam int TXW = (TW > bfir_pkg::ARG_W) ? TW : bfir_pkg::ARG_W;
  localparam int PXW = (PW > bfir_pkg::ARG_W) ? PW : bfir_pkg::ARG_W;
  localparam bit TAPE_POW2 = (TAPE_CELLS & (TAPE_CELLS - 1)) == 0;
  localparam bit PROG_POW2 = (PROGRAM_OPS & (PROGRAM_OPS - 1)) == 0;
  localparam logic [TW:0]   TAPE_M    = (TW + 1)'(TAPE_CELLS);
  localparam logic [PW:0]   PROG_M    = (PW + 1)'(PROGRAM_OPS);
  localparam logic [TW-1:0] TAPE_LAST = TW'(TAPE_CELLS - 1);
  localparam logic [PW-1:0] PROG_LAST = PW'(PROGRAM_OPS - 1);

  // reciprocals rounded up, exact for every operand magnitude
  localparam int TS = bfir_pkg::MAG_W + TW;
  localparam int PS = bfir_pkg::MAG_W + PW;
  localparam longint TAPE_RCP_L =
    ((longint'(1) << TS) + longint'(TAPE_CELLS) - 1) / longint'(TAPE_CELLS);
  localparam longint PROG_RCP_L =
    ((longint'(1) << PS) + longint'(PROGRAM_OPS) - 1) / longint'(PROGRAM_OPS);
  localparam logic [bfir_pkg::MAG_W:0]   TAPE_RCP = (bfir_pkg::MAG_W + 1)'(TAPE_RCP_L);
  localparam logic [bfir_pkg::MAG_W:0]   PROG_RCP = (bfir_pkg::MAG_W + 1)'(PROG_RCP_L);
  localparam logic [bfir_pkg::MAG_W-1:0] TAPE_MOD = bfir_pkg::MAG_W'(TAPE_CELLS);
  localparam logic [bfir_pkg::MAG_W-1:0] PROG_MOD = bfir_pkg::MAG_W'(PROGRAM_OPS);
  localparam logic [bfir_pkg::RED_CNT_W-1:0] RED_FIRST =
    bfir_pkg::RED_CNT_W'(bfir_pkg::RED_CYCLES);

  // tape ram
  logic [bfir_pkg::BYTE_W-1:0] tape [TAPE_CELLS];
  logic [bfir_pkg::BYTE_W-1:0] rd_data;
  logic                        wr_en;
  logic [TW-1:0]               wr_addr;
  logic [bfir_pkg::BYTE_W-1:0] wr_data;

  // clearing sweep
  logic          clr_busy;
  logic [TW-1:0] clr_addr;

  // architectural state
  logic [TW-1:0] dp;
  logic [PW-1:0] idx;
  logic          halted_flag;

  // execute stage
  logic                               s1_valid;
  bfir_pkg::op_t                      s1_op;
  logic signed [bfir_pkg::ARG_W-1:0]  s1_arg;
  logic [bfir_pkg::BYTE_W-1:0]        s1_in_byte;
  logic                               s1_fwd;
  logic [bfir_pkg::BYTE_W-1:0]        s1_fwd_data;
  logic                               s1_done;

  // remainder unit
  logic [bfir_pkg::RED_CNT_W-1:0] red_left;
  logic [bfir_pkg::MAG_W-1:0]     mag;
  logic [bfir_pkg::PROD_W-1:0]    prod_t;
  logic [bfir_pkg::PROD_W-1:0]    prod_p;
  logic [bfir_pkg::MAG_W-1:0]     quo_t;
  logic [bfir_pkg::MAG_W-1:0]     quo_t_next;
  logic [bfir_pkg::MAG_W-1:0]     quo_p;
  logic [bfir_pkg::MAG_W-1:0]     quo_p_next;
  logic [TW-1:0]                  rem_t;
  logic [TW-1:0]                  rem_t_next;
  logic [PW-1:0]                  rem_p;
  logic [PW-1:0]                  rem_p_next;

  logic                          accept;
  bfir_pkg::op_t                 op_in;
  logic                          red_need;
  logic [bfir_pkg::ARG_W:0]      arg_ext;
  logic [bfir_pkg::ARG_W:0]      arg_abs;

  logic [bfir_pkg::BYTE_W-1:0]   cur_byte;
  logic signed [TXW-1:0]         arg_tx;
  logic signed [PXW-1:0]         arg_px;
  logic [TW-1:0]                 delta_t;
  logic [TW:0]                   dp_sum;
  logic [TW-1:0]                 dp_moved;
  logic [PW-1:0]                 target;
  logic [PW-1:0]                 step_next;
  logic [TW-1:0]                 dp_next;
  logic [PW-1:0]                 idx_next;
  logic                          halted_next;
  logic                          wr_req;
  logic [bfir_pkg::BYTE_W-1:0]   wr_val;
  logic [bfir_pkg::BYTE_W-1:0]   obyte;
  logic [bfir_pkg::COUNT_W-1:0]  ocount;
  logic                          exec_wr;

  assign op_in   = bfir_pkg::op_t'(op);
  assign s1_done = s1_valid && (red_left == '0) && (!out_valid || out_ready);
  // the next read address depends on a move, so a move holds off the next item
  assign in_ready = !clr_busy &&
                    (!s1_valid || (s1_done && s1_op != bfir_pkg::OP_MOVE));
  assign accept  = in_valid && in_ready;

  assign red_need = (op_in == bfir_pkg::OP_MOVE && !TAPE_POW2) ||
                    ((op_in == bfir_pkg::OP_JZ || op_in == bfir_pkg::OP_JNZ) && !PROG_POW2);
  assign arg_ext  = {operand[bfir_pkg::ARG_W-1], operand};
  assign arg_abs  = arg_ext[bfir_pkg::ARG_W] ? (~arg_ext + 1'b1) : arg_ext;

  // first step: quotient of the magnitude, second step: remainder
  assign prod_t     = bfir_pkg::PROD_W'(mag) * bfir_pkg::PROD_W'(TAPE_RCP);
  assign prod_p     = bfir_pkg::PROD_W'(mag) * bfir_pkg::PROD_W'(PROG_RCP);
  assign quo_t_next = bfir_pkg::MAG_W'(prod_t >> TS);
  assign quo_p_next = bfir_pkg::MAG_W'(prod_p >> PS);
  assign rem_t_next = TW'(mag - bfir_pkg::MAG_W'(quo_t * TAPE_MOD));
  assign rem_p_next = PW'(mag - bfir_pkg::MAG_W'(quo_p * PROG_MOD));

  assign cur_byte = s1_fwd ? s1_fwd_data : rd_data;
  assign arg_tx   = TXW'(s1_arg);
  assign arg_px   = PXW'(s1_arg);

  // non-negative residues of the operand
  always_comb begin
    if (TAPE_POW2) begin
      delta_t = arg_tx[TW-1:0];
    end else if (s1_arg[bfir_pkg::ARG_W-1] && rem_t != '0) begin
      delta_t = TW'(TAPE_M - {1'b0, rem_t});
    end else begin
      delta_t = rem_t;
    end
    if (PROG_POW2) begin
      target = arg_px[PW-1:0];
    end else if (s1_arg[bfir_pkg::ARG_W-1] && rem_p != '0) begin
      target = PW'(PROG_M - {1'b0, rem_p});
    end else begin
      target = rem_p;
    end
  end

  assign dp_sum    = {1'b0, dp} + {1'b0, delta_t};
  assign dp_moved  = (dp_sum >= TAPE_M) ? TW'(dp_sum - TAPE_M) : dp_sum[TW-1:0];
  assign step_next = (idx == PROG_LAST) ? '0 : idx + 1'b1;

  always_comb begin
    dp_next     = dp;
    idx_next    = idx;
    halted_next = halted_flag;
    wr_req      = 1'b0;
    wr_val      = '0;
    obyte       = '0;
    ocount      = '0;
    if (!halted_flag) begin
      unique case (s1_op) inside
        bfir_pkg::OP_ADD: begin
          wr_req   = 1'b1;
          wr_val   = cur_byte + s1_arg[bfir_pkg::BYTE_W-1:0];
          idx_next = step_next;
        end
        bfir_pkg::OP_MOVE: begin
          dp_next  = dp_moved;
          idx_next = step_next;
        end
        bfir_pkg::OP_ZERO: begin
          wr_req   = 1'b1;
          idx_next = step_next;
        end
        bfir_pkg::OP_OUT: begin
          if (!s1_arg[bfir_pkg::ARG_W-1] && s1_arg != '0) begin
            ocount = s1_arg[bfir_pkg::COUNT_W-1:0];
            obyte  = cur_byte;
          end
          idx_next = step_next;
        end
        bfir_pkg::OP_IN: begin
          wr_req   = 1'b1;
          wr_val   = s1_in_byte;
          idx_next = step_next;
        end
        bfir_pkg::OP_JZ, bfir_pkg::OP_JNZ: begin
          idx_next = ((cur_byte == '0) == (s1_op == bfir_pkg::OP_JZ)) ? target : step_next;
        end
        bfir_pkg::OP_HALT: begin
          halted_next = 1'b1;
        end
      endcase
    end
  end

  assign exec_wr = s1_done && wr_req;
  assign wr_en   = clr_busy || exec_wr;
  assign wr_addr = clr_busy ? clr_addr : dp;
  assign wr_data = clr_busy ? '0 : wr_val;

  always_ff @(posedge clk) begin
    if (wr_en) tape[wr_addr] <= wr_data;
    if (accept) rd_data <= tape[dp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy    <= 1'b1;
      clr_addr    <= '0;
      dp          <= '0;
      idx         <= '0;
      halted_flag <= 1'b0;
      s1_valid    <= 1'b0;
      red_left    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == TAPE_LAST) clr_busy <= 1'b0;
      end
      if (accept) begin
        s1_valid <= 1'b1;
        red_left <= red_need ? RED_FIRST : '0;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end else if (red_left != '0) begin
        red_left <= red_left - 1'b1;
      end
      if (s1_done) begin
        dp          <= dp_next;
        idx         <= idx_next;
        halted_flag <= halted_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op       <= op_in;
      s1_arg      <= operand;
      s1_in_byte  <= in_byte;
      // same cell is written by the item leaving execute at this edge
      s1_fwd      <= exec_wr;
      s1_fwd_data <= wr_val;
      mag         <= arg_abs[bfir_pkg::ARG_W-1:0];
    end else if (red_left == RED_FIRST) begin
      quo_t <= quo_t_next;
      quo_p <= quo_p_next;
    end else if (red_left != '0) begin
      rem_t <= rem_t_next;
      rem_p <= rem_p_next;
    end
    if (s1_done) begin
      next_index <= bfir_pkg::IDX_OUT_W'(idx_next);
      out_byte   <= obyte;
      out_count  <= ocount;
      halted     <= halted_next;
    end
  end

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halted_flag |=> halted_flag)
    else $error("halted flag cleared without reset");

  a_dp_only_on_move: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && !$stable(dp)) |-> $past(s1_done && s1_op == bfir_pkg::OP_MOVE))
    else $error("data pointer changed outside a move");

  a_no_write_halted: assert property (@(posedge clk) disable iff (rst)
    exec_wr |-> !halted_flag)
    else $error("tape written after halt");

  a_red_needs_item: assert property (@(posedge clk) disable iff (rst)
    (red_left != '0) |-> s1_valid)
    else $error("remainder unit running with no item");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> (!s1_valid && !out_valid))
    else $error("item in flight during tape clear");

endmodule

`default_nettype wire
